FILE: sv/bscp_pkg.sv
// ============================================================================
// bscp_pkg
// Shared types, codes and table functions for the five-bit shift code
// translator.
// ============================================================================
package bscp_pkg;

    // Shift and filler codes of the five-bit alphabet
    localparam logic [4:0] FIGS_CODE  = 5'h1B;
    localparam logic [4:0] LTRS_CODE  = 5'h1F;
    localparam logic [4:0] SPACE_CODE = 5'h04;

    // Operation codes
    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    // Configuration register map
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PARITY_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EVEN_PARITY   = 1'd1;

    // Result queue depth (must hold two results of one item, so at least 2)
    localparam int unsigned RQ_DEPTH = 4;

    typedef struct packed {
        logic [7:0] out_value;
        logic       out_present;
        logic       parity_error;
        logic       last;
    } result_t;

    // Translator output: one or two results plus the mode left behind
    typedef struct packed {
        logic    two;
        result_t res_a;
        result_t res_b;
        logic    next_mode;
    } xlate_t;

    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } lookup_t;

    // Letters table, code to character
    function automatic logic [7:0] ltrs_char(input logic [4:0] code);
        logic [7:0] ch;
        unique case (code)
            5'd0:  ch = 8'h00;
            5'd1:  ch = "E";
            5'd2:  ch = 8'h0A;
            5'd3:  ch = "A";
            5'd4:  ch = " ";
            5'd5:  ch = "S";
            5'd6:  ch = "I";
            5'd7:  ch = "U";
            5'd8:  ch = 8'h0D;
            5'd9:  ch = "D";
            5'd10: ch = "R";
            5'd11: ch = "J";
            5'd12: ch = "N";
            5'd13: ch = "F";
            5'd14: ch = "C";
            5'd15: ch = "K";
            5'd16: ch = "T";
            5'd17: ch = "Z";
            5'd18: ch = "L";
            5'd19: ch = "W";
            5'd20: ch = "H";
            5'd21: ch = "Y";
            5'd22: ch = "P";
            5'd23: ch = "Q";
            5'd24: ch = "O";
            5'd25: ch = "B";
            5'd26: ch = "G";
            5'd27: ch = " ";
            5'd28: ch = "M";
            5'd29: ch = "X";
            5'd30: ch = "V";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Figures table, code to character
    function automatic logic [7:0] figs_char(input logic [4:0] code);
        logic [7:0] ch;
        unique case (code)
            5'd0:  ch = 8'h00;
            5'd1:  ch = "3";
            5'd2:  ch = 8'h0A;
            5'd3:  ch = "-";
            5'd4:  ch = " ";
            5'd5:  ch = 8'h07;
            5'd6:  ch = "8";
            5'd7:  ch = "7";
            5'd8:  ch = 8'h0D;
            5'd9:  ch = "2";
            5'd10: ch = "4";
            5'd11: ch = 8'h07;
            5'd12: ch = ",";
            5'd13: ch = "!";
            5'd14: ch = ":";
            5'd15: ch = "(";
            5'd16: ch = "5";
            5'd17: ch = 8'h22;
            5'd18: ch = ")";
            5'd19: ch = "2";
            5'd20: ch = "#";
            5'd21: ch = "6";
            5'd22: ch = "0";
            5'd23: ch = "1";
            5'd24: ch = "9";
            5'd25: ch = "?";
            5'd26: ch = "&";
            5'd27: ch = " ";
            5'd28: ch = ".";
            5'd29: ch = "/";
            5'd30: ch = "=";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Letters table, character to lowest matching code
    function automatic lookup_t ltrs_find(input logic [7:0] ch);
        lookup_t r;
        r.found = 1'b1;
        unique case (ch)
            8'h00: r.idx = 5'd0;
            "E":   r.idx = 5'd1;
            8'h0A: r.idx = 5'd2;
            "A":   r.idx = 5'd3;
            " ":   r.idx = 5'd4;
            "S":   r.idx = 5'd5;
            "I":   r.idx = 5'd6;
            "U":   r.idx = 5'd7;
            8'h0D: r.idx = 5'd8;
            "D":   r.idx = 5'd9;
            "R":   r.idx = 5'd10;
            "J":   r.idx = 5'd11;
            "N":   r.idx = 5'd12;
            "F":   r.idx = 5'd13;
            "C":   r.idx = 5'd14;
            "K":   r.idx = 5'd15;
            "T":   r.idx = 5'd16;
            "Z":   r.idx = 5'd17;
            "L":   r.idx = 5'd18;
            "W":   r.idx = 5'd19;
            "H":   r.idx = 5'd20;
            "Y":   r.idx = 5'd21;
            "P":   r.idx = 5'd22;
            "Q":   r.idx = 5'd23;
            "O":   r.idx = 5'd24;
            "B":   r.idx = 5'd25;
            "G":   r.idx = 5'd26;
            "M":   r.idx = 5'd28;
            "X":   r.idx = 5'd29;
            "V":   r.idx = 5'd30;
            default:
            begin
                r.found = 1'b0;
                r.idx   = SPACE_CODE;
            end
        endcase
        return r;
    endfunction

    // Figures table, character to lowest matching code
    function automatic lookup_t figs_find(input logic [7:0] ch);
        lookup_t r;
        r.found = 1'b1;
        unique case (ch)
            8'h00: r.idx = 5'd0;
            "3":   r.idx = 5'd1;
            8'h0A: r.idx = 5'd2;
            "-":   r.idx = 5'd3;
            " ":   r.idx = 5'd4;
            8'h07: r.idx = 5'd5;
            "8":   r.idx = 5'd6;
            "7":   r.idx = 5'd7;
            8'h0D: r.idx = 5'd8;
            "2":   r.idx = 5'd9;
            "4":   r.idx = 5'd10;
            ",":   r.idx = 5'd12;
            "!":   r.idx = 5'd13;
            ":":   r.idx = 5'd14;
            "(":   r.idx = 5'd15;
            "5":   r.idx = 5'd16;
            8'h22: r.idx = 5'd17;
            ")":   r.idx = 5'd18;
            "#":   r.idx = 5'd20;
            "6":   r.idx = 5'd21;
            "0":   r.idx = 5'd22;
            "1":   r.idx = 5'd23;
            "9":   r.idx = 5'd24;
            "?":   r.idx = 5'd25;
            "&":   r.idx = 5'd26;
            ".":   r.idx = 5'd28;
            "/":   r.idx = 5'd29;
            "=":   r.idx = 5'd30;
            default:
            begin
                r.found = 1'b0;
                r.idx   = SPACE_CODE;
            end
        endcase
        return r;
    endfunction

    // Five-bit code with optional parity in bit 5
    function automatic logic [7:0] add_parity(input logic [4:0] code,
                                              input logic       par_en,
                                              input logic       even);
        logic odd;
        logic set;
        odd = ^code;
        set = even ? odd : ~odd;
        return {2'b00, par_en & set, code};
    endfunction

endpackage

FILE: sv/bscp_if.sv
// ============================================================================
// bscp channel interfaces
// Request, result and configuration write channels, valid/ready handshake.
// ============================================================================
interface bscp_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic       start_req;
    logic [7:0] in_value;

    modport source (output valid, operation, start_req, in_value, input ready);
    modport sink   (input valid, operation, start_req, in_value, output ready);
endinterface

interface bscp_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_value;
    logic       out_present;
    logic       parity_error;
    logic       last;

    modport source (output valid, out_value, out_present, parity_error, last,
                    input ready);
    modport sink   (input valid, out_value, out_present, parity_error, last,
                    output ready);
endinterface

interface bscp_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] reg_index;
    logic       wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

FILE: sv/bscp_xlate.sv
// ============================================================================
// bscp_xlate
// Translation logic for one registered item: encode or decode, parity and
// the letters/figures mode update.
// ============================================================================
module bscp_xlate
(
    input  logic              operation,
    input  logic              start_req,
    input  logic [7:0]        in_value,
    input  logic              mode,
    input  logic              parity_enable,
    input  logic              even_parity,
    output bscp_pkg::xlate_t  xl
);
    import bscp_pkg::*;

    logic       mode_cur;
    logic [7:0] ch_up;
    lookup_t    hit_l;
    lookup_t    hit_f;
    logic       need;
    logic [4:0] enc_idx;
    logic [4:0] code;
    logic [7:0] dec_ch;
    logic       perr;

    // start of message forces letters mode
    assign mode_cur = start_req ? 1'b0 : mode;

    // encode: upper-case a..z, look up both tables
    assign ch_up   = (in_value >= "a" && in_value <= "z") ? (in_value - 8'h20) : in_value;
    assign hit_l   = ltrs_find(ch_up);
    assign hit_f   = figs_find(ch_up);
    assign need    = hit_f.found & ~hit_l.found;
    assign enc_idx = need ? hit_f.idx : hit_l.idx;

    // decode: parity over bits 0..5, table lookup on the low five bits
    assign code   = in_value[4:0];
    assign dec_ch = mode_cur ? figs_char(code) : ltrs_char(code);
    assign perr   = parity_enable & (even_parity ? (^in_value[5:0]) : ~(^in_value[5:0]));

    // result assembly
    always_comb
    begin
        xl = '0;
        if (operation == OP_ENCODE)
        begin
            xl.next_mode = need;
            if (need != mode_cur)
            begin
                xl.two                = 1'b1;
                xl.res_a.out_value    = add_parity(need ? FIGS_CODE : LTRS_CODE,
                                                   parity_enable, even_parity);
                xl.res_a.out_present  = 1'b1;
                xl.res_b.out_value    = add_parity(enc_idx, parity_enable, even_parity);
                xl.res_b.out_present  = 1'b1;
                xl.res_b.last         = 1'b1;
            end
            else
            begin
                xl.res_a.out_value    = add_parity(enc_idx, parity_enable, even_parity);
                xl.res_a.out_present  = 1'b1;
                xl.res_a.last         = 1'b1;
            end
        end
        else
        begin
            xl.res_a.parity_error = perr;
            xl.res_a.last         = 1'b1;
            priority if (code == FIGS_CODE)
            begin
                xl.next_mode = 1'b1;
            end
            else if (code == LTRS_CODE)
            begin
                xl.next_mode = 1'b0;
            end
            else
            begin
                xl.next_mode         = mode_cur;
                xl.res_a.out_value   = dec_ch;
                xl.res_a.out_present = (dec_ch != 8'h00);
            end
        end
    end

endmodule

FILE: sv/bscp_rq.sv
// ============================================================================
// bscp_rq
// Result queue: takes one or two results per cycle, hands out one per
// transaction on the result channel.
// ============================================================================
module bscp_rq
#(
    parameter int unsigned DEPTH = bscp_pkg::RQ_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bscp_pkg::xlate_t  xl,
    output logic              room,
    bscp_rsp_if.source        rsp
);
    import bscp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX  = CNT_W'(DEPTH - 2);

    result_t          store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_b;
    logic             pop;
    logic [1:0]       n_push;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_b = ptr_inc(wr_ptr_reg);
    assign pop      = rsp.valid & rsp.ready;
    assign n_push   = push ? (xl.two ? 2'd2 : 2'd1) : 2'd0;
    assign room     = (count_reg <= ROOM_MAX);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push)
        begin
            wr_ptr_next = xl.two ? ptr_inc(wr_ptr_b) : wr_ptr_b;
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= xl.res_a;
            if (xl.two)
            begin
                store_reg[wr_ptr_b] <= xl.res_b;
            end
        end
    end

    // head of queue to the result channel
    assign rsp.valid        = (count_reg != '0);
    assign rsp.out_value    = store_reg[rd_ptr_reg].out_value;
    assign rsp.out_present  = store_reg[rd_ptr_reg].out_present;
    assign rsp.parity_error = store_reg[rd_ptr_reg].parity_error;
    assign rsp.last         = store_reg[rd_ptr_reg].last;

endmodule

FILE: sv/baudot_shift_codec_with_parity_top.sv
// ============================================================================
// baudot_shift_codec_with_parity_top
// Five-bit shift code translator (letters/figures) with optional parity.
// ============================================================================
// Each request transaction is captured in an input register; from there it is
// translated and its one or two results enter a small result queue once the
// queue has space for two results. A request can be accepted every cycle as
// long as the queue has space for two results; the result channel moves one
// result per cycle while the receiver is ready, so an encode that needs a shift
// code puts two results on the result channel, the shift code first.
// Configuration writes are always accepted and are registered before they take effect.
module baudot_shift_codec_with_parity_top
#(
    parameter int unsigned RQ_DEPTH = bscp_pkg::RQ_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    bscp_req_if.sink    req,
    bscp_rsp_if.source  rsp,
    bscp_cfg_if.sink    cfg
);
    import bscp_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_op_reg;
    logic       s1_start_reg;
    logic [7:0] s1_value_reg;
    logic       mode_reg, mode_next;
    logic       par_en_reg;
    logic       even_reg;
    logic       room;
    logic       advance;
    logic       accept;
    xlate_t     xl;

    // input register handshake
    assign advance   = s1_valid_reg & room;
    assign req.ready = ~s1_valid_reg | room;
    assign accept    = req.valid & req.ready;
    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign mode_next     = advance ? xl.next_mode : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            mode_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            mode_reg     <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= req.operation;
            s1_start_reg <= req.start_req;
            s1_value_reg <= req.in_value;
        end
    end

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_en_reg <= 1'b0;
            even_reg   <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_PARITY_ENABLE: par_en_reg <= cfg.wr_data;
                REG_EVEN_PARITY:   even_reg   <= cfg.wr_data;
                default:           ;
            endcase
        end
    end

    // translation
    bscp_xlate u_xlate
    (
        .operation     (s1_op_reg),
        .start_req     (s1_start_reg),
        .in_value      (s1_value_reg),
        .mode          (mode_reg),
        .parity_enable (par_en_reg),
        .even_parity   (even_reg),
        .xl            (xl)
    );

    // result queue
    bscp_rq #(.DEPTH(RQ_DEPTH)) u_rq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (advance),
        .xl    (xl),
        .room  (room),
        .rsp   (rsp)
    );

    // checks
    a_shift_then_char: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && xl.two) |-> (!xl.res_a.last && xl.res_b.last))
        else $error("two-result item without last on second result only");

    a_pair_together: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && !rsp.last) |=> rsp.valid)
        else $error("second result of an item missing from the queue");

    a_ltrs_clears_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_op_reg == OP_DECODE && s1_value_reg[4:0] == LTRS_CODE)
        |=> !mode_reg)
        else $error("letters shift did not clear figures mode");

    a_no_accept_without_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !room) |-> !req.ready)
        else $error("request taken while input register is blocked");

endmodule
